// ===== hw/rtl/ttl_pkg.sv =====
`timescale 1ns / 1ps

package ttl_pkg;

  // field and register widths
  localparam int unsigned SIZE_W   = 7;
  localparam int unsigned MASK_W   = 9;
  localparam int unsigned CFG_W    = 9;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned COORD_W  = 6;
  localparam int unsigned COUNT_W  = 13;
  localparam int unsigned NBR_W    = 4;

  // grid geometry
  localparam int unsigned MAX_WIDTH_DEF  = 64;
  localparam int unsigned MAX_HEIGHT_DEF = 64;
  localparam int unsigned MIN_SIZE       = 3;

  // register reset values
  localparam logic [SIZE_W-1:0]  GRID_WIDTH_RST   = 7'd64;
  localparam logic [SIZE_W-1:0]  GRID_HEIGHT_RST  = 7'd64;
  localparam logic [MASK_W-1:0]  BIRTH_MASK_RST   = 9'd8;
  localparam logic [MASK_W-1:0]  SURVIVE_MASK_RST = 9'd12;

  localparam logic [COUNT_W-1:0] COUNT_MAX = {COUNT_W{1'b1}};

  typedef enum logic [1:0] {
    OP_SET   = 2'd0,
    OP_STEP  = 2'd1,
    OP_CLEAR = 2'd2
  } op_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GRID_WIDTH   = 2'd0,
    CFG_GRID_HEIGHT  = 2'd1,
    CFG_BIRTH_MASK   = 2'd2,
    CFG_SURVIVE_MASK = 2'd3
  } cfg_idx_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_CLEAR,
    ST_GEN_UP,
    ST_GEN_CUR,
    ST_GEN_DN,
    ST_GEN_FILL,
    ST_CELL,
    ST_ROW_END,
    ST_ROW_LOAD,
    ST_RPT_RD,
    ST_RPT,
    ST_DONE
  } state_e;

  typedef struct packed {
    logic [1:0]         op;
    logic [COORD_W-1:0] col;
    logic [COORD_W-1:0] row;
  } in_item_t;

  typedef struct packed {
    logic [COUNT_W-1:0] live_count;
    logic               cell_alive;
    logic               bad_coord;
  } out_item_t;

  // row memory control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clr;
  } mem_ctrl_t;

endpackage

// ===== hw/rtl/toroidal_life_like_automaton_top.sv =====
`timescale 1ns / 1ps

// set cell: the row is read, then written with the cell set; a bad coordinate skips both; clear: all rows at once
// report only (unused op): the row is read and the cell taken, a bad coordinate skips the read
// generation: window load, then row by row a sweep of one cell per cycle in the rule unit
// one item at a time; the next beat is taken as soon as the result sits in the output register
// async active-low reset: all cells dead via per-row valid bits, no clearing pass, count zero
module toroidal_life_like_automaton_top import ttl_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_wdata_i,
  input  logic                 in_valid_i,
  output logic                 in_stall_o,
  input  in_item_t             in_item_i,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output out_item_t            out_item_o
);

  localparam int unsigned CW  = $clog2(MAX_WIDTH);
  localparam int unsigned RW  = $clog2(MAX_HEIGHT);
  localparam int unsigned UWW = $clog2(MAX_WIDTH + 1);
  localparam int unsigned UHW = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned SWW = (UWW > SIZE_W) ? UWW : SIZE_W;
  localparam int unsigned SHW = (UHW > SIZE_W) ? UHW : SIZE_W;

  logic [SIZE_W-1:0] grid_width_q, grid_width_d;
  logic [SIZE_W-1:0] grid_height_q, grid_height_d;
  logic [MASK_W-1:0] birth_mask_q, birth_mask_d;
  logic [MASK_W-1:0] survive_mask_q, survive_mask_d;
  logic              size_clr;

  logic [SWW-1:0]    gw_ext;
  logic [SHW-1:0]    gh_ext;
  logic [UWW-1:0]    used_w;
  logic [UHW-1:0]    used_h;

  mem_ctrl_t         mem_ctrl;
  logic [RW-1:0]     waddr, raddr;
  logic [MAX_WIDTH-1:0] wdata, rdata;
  logic [MAX_WIDTH-1:0] up_row, cur_row, dn_row;
  logic [CW-1:0]     col, col_l, col_r;
  logic              cell_next;

  // configuration writes
  always_comb begin
    grid_width_d   = grid_width_q;
    grid_height_d  = grid_height_q;
    birth_mask_d   = birth_mask_q;
    survive_mask_d = survive_mask_q;
    size_clr       = 1'b0;
    if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_GRID_WIDTH: begin
          grid_width_d = cfg_wdata_i[SIZE_W-1:0];
          size_clr     = 1'b1;
        end
        CFG_GRID_HEIGHT: begin
          grid_height_d = cfg_wdata_i[SIZE_W-1:0];
          size_clr      = 1'b1;
        end
        CFG_BIRTH_MASK:   birth_mask_d   = cfg_wdata_i[MASK_W-1:0];
        CFG_SURVIVE_MASK: survive_mask_d = cfg_wdata_i[MASK_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      grid_width_q   <= GRID_WIDTH_RST;
      grid_height_q  <= GRID_HEIGHT_RST;
      birth_mask_q   <= BIRTH_MASK_RST;
      survive_mask_q <= SURVIVE_MASK_RST;
    end else begin
      grid_width_q   <= grid_width_d;
      grid_height_q  <= grid_height_d;
      birth_mask_q   <= birth_mask_d;
      survive_mask_q <= survive_mask_d;
    end
  end

  // used size, clamped to the minimum and to the storage bound
  assign gw_ext = SWW'(grid_width_q);
  assign gh_ext = SHW'(grid_height_q);

  always_comb begin
    if (gw_ext < SWW'(MIN_SIZE)) begin
      used_w = UWW'(MIN_SIZE);
    end else if (gw_ext > SWW'(MAX_WIDTH)) begin
      used_w = UWW'(MAX_WIDTH);
    end else begin
      used_w = UWW'(gw_ext);
    end
    if (gh_ext < SHW'(MIN_SIZE)) begin
      used_h = UHW'(MIN_SIZE);
    end else if (gh_ext > SHW'(MAX_HEIGHT)) begin
      used_h = UHW'(MAX_HEIGHT);
    end else begin
      used_h = UHW'(gh_ext);
    end
  end

  ttl_row_mem #(
    .ROWS (MAX_HEIGHT),
    .COLS (MAX_WIDTH)
  ) u_row_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (mem_ctrl),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  ttl_cell_unit #(
    .COLS (MAX_WIDTH)
  ) u_cell_unit (
    .up_i           (up_row),
    .cur_i          (cur_row),
    .dn_i           (dn_row),
    .col_i          (col),
    .col_l_i        (col_l),
    .col_r_i        (col_r),
    .birth_mask_i   (birth_mask_q),
    .survive_mask_i (survive_mask_q),
    .alive_o        (cell_next)
  );

  ttl_seq #(
    .MAX_WIDTH  (MAX_WIDTH),
    .MAX_HEIGHT (MAX_HEIGHT)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_item_i   (in_item_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_item_o  (out_item_o),
    .used_w_i    (used_w),
    .used_h_i    (used_h),
    .size_clr_i  (size_clr),
    .mem_ctrl_o  (mem_ctrl),
    .waddr_o     (waddr),
    .wdata_o     (wdata),
    .raddr_o     (raddr),
    .rdata_i     (rdata),
    .up_o        (up_row),
    .cur_o       (cur_row),
    .dn_o        (dn_row),
    .col_o       (col),
    .col_l_o     (col_l),
    .col_r_o     (col_r),
    .alive_i     (cell_next)
  );

endmodule

// ===== hw/rtl/ttl_row_mem.sv =====
`timescale 1ns / 1ps

module ttl_row_mem import ttl_pkg::*; #(
  parameter int unsigned ROWS = MAX_HEIGHT_DEF,
  parameter int unsigned COLS = MAX_WIDTH_DEF
) (
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  mem_ctrl_t               ctrl_i,
  input  logic [$clog2(ROWS)-1:0] waddr_i,
  input  logic [COLS-1:0]         wdata_i,
  input  logic [$clog2(ROWS)-1:0] raddr_i,
  output logic [COLS-1:0]         rdata_o
);

  logic [COLS-1:0] mem_q [ROWS];
  logic [ROWS-1:0] row_valid_q;
  logic [COLS-1:0] rd_data_q;
  logic            rd_valid_q;

  // row storage, one write and one registered read per cycle
  always_ff @(posedge clk_i) begin
    if (ctrl_i.wr_en) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd_en) begin
      rd_data_q <= mem_q[raddr_i];
    end
  end

  // per-row valid bits, a row never written reads as all dead
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_valid_q <= '0;
      rd_valid_q  <= 1'b0;
    end else begin
      if (ctrl_i.clr) begin
        row_valid_q <= '0;
      end else if (ctrl_i.wr_en) begin
        row_valid_q[waddr_i] <= 1'b1;
      end
      if (ctrl_i.rd_en) begin
        rd_valid_q <= row_valid_q[raddr_i];
      end
    end
  end

  assign rdata_o = rd_valid_q ? rd_data_q : '0;

endmodule

// ===== hw/rtl/ttl_cell_unit.sv =====
`timescale 1ns / 1ps

module ttl_cell_unit import ttl_pkg::*; #(
  parameter int unsigned COLS = MAX_WIDTH_DEF
) (
  input  logic [COLS-1:0]         up_i,
  input  logic [COLS-1:0]         cur_i,
  input  logic [COLS-1:0]         dn_i,
  input  logic [$clog2(COLS)-1:0] col_i,
  input  logic [$clog2(COLS)-1:0] col_l_i,
  input  logic [$clog2(COLS)-1:0] col_r_i,
  input  logic [MASK_W-1:0]       birth_mask_i,
  input  logic [MASK_W-1:0]       survive_mask_i,
  output logic                    alive_o
);

  logic [NBR_W-1:0]  nbr_cnt;
  logic [MASK_W-1:0] rule_mask;

  // eight neighbours of the current cell
  assign nbr_cnt = NBR_W'(up_i[col_l_i]) + NBR_W'(up_i[col_i]) + NBR_W'(up_i[col_r_i])
                 + NBR_W'(cur_i[col_l_i]) + NBR_W'(cur_i[col_r_i])
                 + NBR_W'(dn_i[col_l_i]) + NBR_W'(dn_i[col_i]) + NBR_W'(dn_i[col_r_i]);

  // live cells test the survive rule, dead cells the birth rule
  assign rule_mask = cur_i[col_i] ? survive_mask_i : birth_mask_i;
  assign alive_o   = rule_mask[nbr_cnt];

endmodule

// ===== hw/rtl/ttl_seq.sv =====
`timescale 1ns / 1ps

module ttl_seq import ttl_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = MAX_WIDTH_DEF,
  parameter int unsigned MAX_HEIGHT = MAX_HEIGHT_DEF
) (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               in_valid_i,
  output logic                               in_stall_o,
  input  in_item_t                           in_item_i,
  output logic                               out_valid_o,
  input  logic                               out_stall_i,
  output out_item_t                          out_item_o,
  input  logic [$clog2(MAX_WIDTH+1)-1:0]     used_w_i,
  input  logic [$clog2(MAX_HEIGHT+1)-1:0]    used_h_i,
  input  logic                               size_clr_i,
  output mem_ctrl_t                          mem_ctrl_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]      waddr_o,
  output logic [MAX_WIDTH-1:0]               wdata_o,
  output logic [$clog2(MAX_HEIGHT)-1:0]      raddr_o,
  input  logic [MAX_WIDTH-1:0]               rdata_i,
  output logic [MAX_WIDTH-1:0]               up_o,
  output logic [MAX_WIDTH-1:0]               cur_o,
  output logic [MAX_WIDTH-1:0]               dn_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       col_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       col_l_o,
  output logic [$clog2(MAX_WIDTH)-1:0]       col_r_o,
  input  logic                               alive_i
);

  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned RW    = $clog2(MAX_HEIGHT);
  localparam int unsigned UWW   = $clog2(MAX_WIDTH + 1);
  localparam int unsigned UHW   = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CMP_W = (UWW > COORD_W) ? UWW : COORD_W;
  localparam int unsigned CMP_H = (UHW > COORD_W) ? UHW : COORD_W;
  localparam int unsigned R2W   = UHW + 1;

  state_e             state_q, state_d;
  logic               bad_q, bad_d;
  logic [CW-1:0]      col_q, col_d;
  logic [RW-1:0]      row_q, row_d;
  logic [CW-1:0]      cnt_col_q, cnt_col_d;
  logic [RW-1:0]      cnt_row_q, cnt_row_d;
  logic [MAX_WIDTH-1:0] up_q, up_d, cur_q, cur_d, dn_q, dn_d;
  logic [MAX_WIDTH-1:0] save0_q, save0_d, nxt_q, nxt_d;
  logic [COUNT_W-1:0] total_q, total_d;
  logic [COUNT_W-1:0] live_q, live_d;
  logic               alive_q, alive_d;
  out_item_t          out_q, out_d;
  logic               out_valid_q, out_valid_d;

  logic               accept;
  logic               in_bad;
  logic               last_col;
  logic               last_row;
  logic [R2W-1:0]     row_nx2;

  assign in_stall_o = (state_q != ST_IDLE);
  assign accept     = in_valid_i && !in_stall_o;

  // coordinate check against the used size
  assign in_bad = (CMP_W'(in_item_i.col) >= CMP_W'(used_w_i)) ||
                  (CMP_H'(in_item_i.row) >= CMP_H'(used_h_i));

  // sweep position and torus wrap
  assign last_col = (UWW'(cnt_col_q) == used_w_i - UWW'(1));
  assign last_row = (UHW'(cnt_row_q) == used_h_i - UHW'(1));
  assign row_nx2  = R2W'(cnt_row_q) + R2W'(2);

  assign col_o   = cnt_col_q;
  assign col_l_o = (cnt_col_q == '0) ? CW'(used_w_i - UWW'(1)) : cnt_col_q - CW'(1);
  assign col_r_o = last_col ? '0 : cnt_col_q + CW'(1);
  assign up_o    = up_q;
  assign cur_o   = cur_q;
  assign dn_o    = dn_q;

  // control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      live_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      live_q      <= live_d;
      out_valid_q <= out_valid_d;
    end
  end

  // item, row window and result payload
  always_ff @(posedge clk_i) begin
    bad_q     <= bad_d;
    col_q     <= col_d;
    row_q     <= row_d;
    cnt_col_q <= cnt_col_d;
    cnt_row_q <= cnt_row_d;
    up_q      <= up_d;
    cur_q     <= cur_d;
    dn_q      <= dn_d;
    save0_q   <= save0_d;
    nxt_q     <= nxt_d;
    total_q   <= total_d;
    alive_q   <= alive_d;
    out_q     <= out_d;
  end

  // sequencer
  always_comb begin
    state_d     = state_q;
    bad_d       = bad_q;
    col_d       = col_q;
    row_d       = row_q;
    cnt_col_d   = cnt_col_q;
    cnt_row_d   = cnt_row_q;
    up_d        = up_q;
    cur_d       = cur_q;
    dn_d        = dn_q;
    save0_d     = save0_q;
    nxt_d       = nxt_q;
    total_d     = total_q;
    live_d      = live_q;
    alive_d     = alive_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && out_stall_i;
    mem_ctrl_o  = '0;
    waddr_o     = row_q;
    wdata_o     = rdata_i;
    raddr_o     = row_q;

    if (size_clr_i) begin
      mem_ctrl_o.clr = 1'b1;
      live_d         = '0;
    end

    case (state_q)
      ST_IDLE: begin
        if (accept) begin
          bad_d   = in_bad;
          col_d   = CW'(in_item_i.col);
          row_d   = RW'(in_item_i.row);
          alive_d = 1'b0;
          case (op_e'(in_item_i.op))
            OP_SET:   state_d = in_bad ? ST_DONE : ST_SET_RD;
            OP_STEP:  state_d = ST_GEN_UP;
            OP_CLEAR: state_d = ST_CLEAR;
            default:  state_d = in_bad ? ST_DONE : ST_RPT_RD;
          endcase
        end
      end

      // set one cell by read, modify, write of its row
      ST_SET_RD: begin
        mem_ctrl_o.rd_en = 1'b1;
        state_d          = ST_SET_WR;
      end
      ST_SET_WR: begin
        if (!rdata_i[col_q]) begin
          mem_ctrl_o.wr_en = 1'b1;
          wdata_o[col_q]   = 1'b1;
          live_d           = (live_q == COUNT_MAX) ? live_q : live_q + COUNT_W'(1);
        end
        alive_d = 1'b1;
        state_d = ST_DONE;
      end

      ST_CLEAR: begin
        mem_ctrl_o.clr = 1'b1;
        live_d         = '0;
        state_d        = ST_DONE;
      end

      // load the window: last row above, rows zero and one
      ST_GEN_UP: begin
        mem_ctrl_o.rd_en = 1'b1;
        raddr_o          = RW'(used_h_i - UHW'(1));
        cnt_row_d        = '0;
        cnt_col_d        = '0;
        total_d          = '0;
        nxt_d            = '0;
        state_d          = ST_GEN_CUR;
      end
      ST_GEN_CUR: begin
        up_d             = rdata_i;
        mem_ctrl_o.rd_en = 1'b1;
        raddr_o          = '0;
        state_d          = ST_GEN_DN;
      end
      ST_GEN_DN: begin
        cur_d            = rdata_i;
        save0_d          = rdata_i;
        mem_ctrl_o.rd_en = 1'b1;
        raddr_o          = RW'(1);
        state_d          = ST_GEN_FILL;
      end
      ST_GEN_FILL: begin
        dn_d    = rdata_i;
        state_d = ST_CELL;
      end

      // one cell per cycle through the rule unit
      ST_CELL: begin
        nxt_d[cnt_col_q] = alive_i;
        if (alive_i && (total_q != COUNT_MAX)) begin
          total_d = total_q + COUNT_W'(1);
        end
        if (last_col) begin
          state_d = ST_ROW_END;
        end else begin
          cnt_col_d = cnt_col_q + CW'(1);
        end
      end

      // write the new row back and slide the window down
      ST_ROW_END: begin
        mem_ctrl_o.wr_en = 1'b1;
        waddr_o          = cnt_row_q;
        wdata_o          = nxt_q;
        up_d             = cur_q;
        cur_d            = dn_q;
        nxt_d            = '0;
        cnt_col_d        = '0;
        if (last_row) begin
          live_d  = total_q;
          state_d = bad_q ? ST_DONE : ST_RPT_RD;
        end else begin
          mem_ctrl_o.rd_en = (row_nx2 < R2W'(used_h_i));
          raddr_o          = RW'(row_nx2);
          cnt_row_d        = cnt_row_q + RW'(1);
          state_d          = ST_ROW_LOAD;
        end
      end
      ST_ROW_LOAD: begin
        // the row below the last one is the saved old row zero
        dn_d    = last_row ? save0_q : rdata_i;
        state_d = ST_CELL;
      end

      // read back the cell named by the item
      ST_RPT_RD: begin
        mem_ctrl_o.rd_en = 1'b1;
        state_d          = ST_RPT;
      end
      ST_RPT: begin
        alive_d = rdata_i[col_q];
        state_d = ST_DONE;
      end

      // hand the result to the output register once it is free
      ST_DONE: begin
        if (!out_valid_q || !out_stall_i) begin
          out_d.live_count = live_q;
          out_d.cell_alive = alive_q && !bad_q;
          out_d.bad_coord  = bad_q;
          out_valid_d      = 1'b1;
          state_d          = ST_IDLE;
        end
      end

      default: state_d = ST_IDLE;
    endcase
  end

  assign out_valid_o = out_valid_q;
  assign out_item_o  = out_q;

`ifndef NO_ASSERTIONS
  a_no_wr_with_clr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(mem_ctrl_o.wr_en && mem_ctrl_o.clr))
    else $error("row write coincides with grid clear");

  a_busy_after_beat: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> in_stall_o)
    else $error("input not stalled after an accepted beat");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> (UWW'(cnt_col_q) < used_w_i))
    else $error("sweep column beyond used width");

  a_row_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_CELL) |-> (UHW'(cnt_row_q) < used_h_i))
    else $error("sweep row beyond used height");

  a_gen_total: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ROW_END && last_row) |=> (live_q == $past(total_q)))
    else $error("live count not taken from generation total");
`endif

endmodule

// ===== tb/tb_toroidal_life_like_automaton_top.sv =====
`timescale 1ns / 1ps

module tb_toroidal_life_like_automaton_top;
  import ttl_pkg::*;

  // op code with no action, only a report of the current state
  localparam logic [1:0] OP_NONE = 2'd3;
  localparam int GRID_MAX = 64;

  // one row of the directed plan: a register write or a beat
  typedef struct {
    bit                is_cfg;
    cfg_idx_e          idx;
    logic [CFG_W-1:0]  val;
    in_item_t          item;
    bit                typed;
    out_item_t         want;
  } plan_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_W-1:0]     cfg_wdata;
  logic                 in_valid;
  logic                 in_stall;
  in_item_t             in_item;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_item_t            out_item;

  toroidal_life_like_automaton_top dut (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_item_i   (in_item),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_item_o  (out_item)
  );

  // clock
  initial clk = 1'b0;
  always #10 clk = ~clk;

  // shadow copy of the grid and the rule registers
  bit                life_q   [GRID_MAX][GRID_MAX];
  bit                life_nxt [GRID_MAX][GRID_MAX];
  int                live_q;
  logic [SIZE_W-1:0] width_reg;
  logic [SIZE_W-1:0] height_reg;
  logic [MASK_W-1:0] birth_reg;
  logic [MASK_W-1:0] survive_reg;

  out_item_t  want_q [$];
  plan_row_t  plan_q [$];
  int         beat_cnt;
  int         err_cnt;
  int         stall_left;
  bit         quiet;

  task automatic report_error(input string msg);
    $display("ERROR: %s", msg);
    err_cnt++;
  endtask

  function automatic int used_dim(input logic [SIZE_W-1:0] v, input int max_dim);
    if (v < MIN_SIZE) return MIN_SIZE;
    if (v > max_dim) return max_dim;
    return v;
  endfunction

  function automatic void wipe_grid();
    for (int r = 0; r < GRID_MAX; r++) begin
      for (int c = 0; c < GRID_MAX; c++) life_q[r][c] = 1'b0;
    end
    live_q = 0;
  endfunction

  function automatic void apply_cfg(input cfg_idx_e idx, input logic [CFG_W-1:0] v);
    case (idx)
      CFG_GRID_WIDTH: begin
        width_reg = v[SIZE_W-1:0];
        wipe_grid();
      end
      CFG_GRID_HEIGHT: begin
        height_reg = v[SIZE_W-1:0];
        wipe_grid();
      end
      CFG_BIRTH_MASK:   birth_reg = v[MASK_W-1:0];
      CFG_SURVIVE_MASK: survive_reg = v[MASK_W-1:0];
      default: ;
    endcase
  endfunction

  // one synchronous generation on the torus
  function automatic void advance_grid();
    int w;
    int h;
    int n;
    int total;
    logic [MASK_W-1:0] m;
    w = used_dim(width_reg, MAX_WIDTH_DEF);
    h = used_dim(height_reg, MAX_HEIGHT_DEF);
    total = 0;
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) begin
        n = 0;
        for (int dr = -1; dr <= 1; dr++) begin
          for (int dc = -1; dc <= 1; dc++) begin
            if (dr != 0 || dc != 0) n += life_q[(r + dr + h) % h][(c + dc + w) % w];
          end
        end
        m = life_q[r][c] ? survive_reg : birth_reg;
        life_nxt[r][c] = m[n];
        total += m[n];
      end
    end
    for (int r = 0; r < h; r++) begin
      for (int c = 0; c < w; c++) life_q[r][c] = life_nxt[r][c];
    end
    live_q = (total > COUNT_MAX) ? COUNT_MAX : total;
  endfunction

  // expected result of one beat, updating the shadow state
  function automatic out_item_t predict_beat(input in_item_t it);
    int w;
    int h;
    bit bad;
    out_item_t o;
    w = used_dim(width_reg, MAX_WIDTH_DEF);
    h = used_dim(height_reg, MAX_HEIGHT_DEF);
    bad = (it.col >= w) || (it.row >= h);
    case (it.op)
      OP_SET: begin
        if (!bad && !life_q[it.row][it.col]) begin
          life_q[it.row][it.col] = 1'b1;
          live_q = (live_q + 1 > COUNT_MAX) ? COUNT_MAX : live_q + 1;
        end
      end
      OP_STEP:  advance_grid();
      OP_CLEAR: wipe_grid();
      default: ;
    endcase
    o.live_count = live_q[COUNT_W-1:0];
    o.cell_alive = bad ? 1'b0 : life_q[it.row][it.col];
    o.bad_coord  = bad;
    return o;
  endfunction

  // gap or stall length: mostly short, a few long
  function automatic int pick_len();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic [MASK_W-1:0] pick_mask(input logic [MASK_W-1:0] classic);
    case ($urandom_range(0, 5))
      0:       return '0;
      1:       return '1;
      2, 3:    return classic;
      default: return MASK_W'($urandom_range(0, 511));
    endcase
  endfunction

  // mostly in-range sets and steps, the rest noise over the full field range
  function automatic in_item_t random_beat(input int step_pct);
    int w;
    int h;
    int r;
    in_item_t it;
    w = used_dim(width_reg, MAX_WIDTH_DEF);
    h = used_dim(height_reg, MAX_HEIGHT_DEF);
    r = $urandom_range(0, 99);
    it.col = COORD_W'($urandom_range(0, w - 1));
    it.row = COORD_W'($urandom_range(0, h - 1));
    if (r < 60) begin
      it.op = OP_SET;
    end else if (r < 60 + step_pct) begin
      it.op = OP_STEP;
    end else if (r < 63 + step_pct) begin
      it.op = OP_CLEAR;
    end else if (r < 67 + step_pct) begin
      it.op = OP_NONE;
    end else begin
      it.op  = 2'($urandom_range(0, 3));
      it.col = COORD_W'($urandom_range(0, 63));
      it.row = COORD_W'($urandom_range(0, 63));
    end
    return it;
  endfunction

  function automatic void plan_item(input logic [1:0] op, input int col, input int row,
                                    input bit typed, input int cnt, input bit alive,
                                    input bit bad);
    plan_row_t p;
    p.is_cfg = 1'b0;
    p.idx = CFG_GRID_WIDTH;
    p.val = '0;
    p.item.op = op;
    p.item.col = COORD_W'(col);
    p.item.row = COORD_W'(row);
    p.typed = typed;
    p.want.live_count = COUNT_W'(cnt);
    p.want.cell_alive = alive;
    p.want.bad_coord = bad;
    plan_q.push_back(p);
  endfunction

  function automatic void plan_cfg(input cfg_idx_e idx, input int v);
    plan_row_t p;
    p.is_cfg = 1'b1;
    p.idx = idx;
    p.val = CFG_W'(v);
    p.item = '0;
    p.typed = 1'b0;
    p.want = '0;
    plan_q.push_back(p);
  endfunction

  // drive one input beat and record its expected result on acceptance
  task automatic send_beat(input in_item_t it, input bit typed, input out_item_t typed_want);
    int gap;
    out_item_t p;
    gap = pick_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = it;
    in_valid = 1'b1;
    do @(posedge clk); while (in_stall);
    p = predict_beat(it);
    want_q.push_back(typed ? typed_want : p);
    @(negedge clk);
  endtask

  // register write once the block has drained
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] v);
    in_valid = 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
    cfg_we    = 1'b1;
    cfg_idx   = idx;
    cfg_wdata = v;
    apply_cfg(idx, v);
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  // output stall pattern
  always @(negedge clk) begin : stall_gen
    if (quiet) begin
      out_stall  = 1'b0;
      stall_left = 0;
    end else if (stall_left > 0) begin
      stall_left--;
    end else begin
      out_stall  = 1'($urandom_range(0, 1));
      stall_left = pick_len();
    end
  end

  // compare each result beat with the oldest expectation
  always @(posedge clk) begin : check_blk
    out_item_t w;
    if (rst_n && out_valid && !out_stall) begin
      if (want_q.size() == 0) begin
        report_error($sformatf("result beat %0d with no expected result", beat_cnt));
      end else begin
        w = want_q.pop_front();
        if (out_item.live_count !== w.live_count)
          report_error($sformatf("beat %0d live_count got %0d want %0d",
                                 beat_cnt, out_item.live_count, w.live_count));
        if (out_item.cell_alive !== w.cell_alive)
          report_error($sformatf("beat %0d cell_alive got %0b want %0b",
                                 beat_cnt, out_item.cell_alive, w.cell_alive));
        if (out_item.bad_coord !== w.bad_coord)
          report_error($sformatf("beat %0d bad_coord got %0b want %0b",
                                 beat_cnt, out_item.bad_coord, w.bad_coord));
      end
      beat_cnt++;
    end
  end

  // run limit
  initial begin
    #(100_000_000);
    $display("simulation failed");
    $finish;
  end

  initial begin : main
    int step_pct;
    int w;
    int h;
    logic [CFG_W-1:0] wv;
    logic [CFG_W-1:0] hv;
    in_item_t it;

    rst_n     = 1'b0;
    cfg_we    = 1'b0;
    cfg_idx   = '0;
    cfg_wdata = '0;
    in_valid  = 1'b0;
    in_item   = '0;
    quiet     = 1'b0;
    beat_cnt  = 0;
    err_cnt   = 0;
    stall_left = 0;
    width_reg   = GRID_WIDTH_RST;
    height_reg  = GRID_HEIGHT_RST;
    birth_reg   = BIRTH_MASK_RST;
    survive_reg = SURVIVE_MASK_RST;
    wipe_grid();

    // directed plan, reset rule B3/S23 on 64 by 64
    plan_item(OP_SET, 0, 0, 1, 1, 1, 0);
    plan_item(OP_SET, 63, 63, 1, 2, 1, 0);
    // setting a live cell changes nothing
    plan_item(OP_SET, 63, 63, 1, 2, 1, 0);
    plan_item(OP_NONE, 0, 0, 1, 2, 1, 0);
    plan_item(OP_SET, 0, 63, 1, 3, 1, 0);
    plan_item(OP_SET, 63, 0, 1, 4, 1, 0);
    // four corners form a block across the wrap
    plan_item(OP_STEP, 63, 0, 0, 0, 0, 0);
    plan_item(OP_SET, 42, 21, 1, 5, 1, 0);
    plan_item(OP_STEP, 42, 21, 0, 0, 0, 0);
    plan_item(OP_CLEAR, 0, 0, 1, 0, 0, 0);
    // glider
    plan_item(OP_SET, 1, 0, 1, 1, 1, 0);
    plan_item(OP_SET, 2, 1, 1, 2, 1, 0);
    plan_item(OP_SET, 0, 2, 1, 3, 1, 0);
    plan_item(OP_SET, 1, 2, 1, 4, 1, 0);
    plan_item(OP_SET, 2, 2, 1, 5, 1, 0);
    plan_item(OP_STEP, 1, 2, 0, 0, 0, 0);
    plan_item(OP_STEP, 2, 3, 0, 0, 0, 0);
    // small grid, coordinates past the used area
    plan_cfg(CFG_GRID_WIDTH, 10);
    plan_cfg(CFG_GRID_HEIGHT, 5);
    plan_item(OP_SET, 10, 0, 1, 0, 0, 1);
    plan_item(OP_SET, 0, 5, 1, 0, 0, 1);
    plan_item(OP_STEP, 63, 63, 1, 0, 0, 1);
    plan_item(OP_SET, 9, 4, 1, 1, 1, 0);
    // saturated sizes: width 127 acts as 64, height 0 as 3
    plan_cfg(CFG_GRID_WIDTH, 9'h1FF);
    plan_cfg(CFG_GRID_HEIGHT, 0);
    plan_item(OP_SET, 63, 2, 1, 1, 1, 0);
    plan_item(OP_SET, 0, 3, 1, 1, 0, 1);
    plan_item(OP_SET, 0, 1, 1, 2, 1, 0);
    // mask extremes, grid kept across mask writes
    plan_cfg(CFG_BIRTH_MASK, 511);
    plan_cfg(CFG_SURVIVE_MASK, 0);
    plan_item(OP_STEP, 0, 0, 0, 0, 0, 0);
    plan_cfg(CFG_BIRTH_MASK, 0);
    plan_cfg(CFG_SURVIVE_MASK, 511);
    plan_item(OP_STEP, 5, 1, 0, 0, 0, 0);

    // reset
    repeat (10) @(negedge clk);
    rst_n = 1'b1;
    repeat (2) @(negedge clk);

    foreach (plan_q[k]) begin
      if (plan_q[k].is_cfg) write_reg(plan_q[k].idx, plan_q[k].val);
      else send_beat(plan_q[k].item, plan_q[k].typed, plan_q[k].want);
    end

    // random phases, each with its own size and rule
    for (int p = 0; p < 7; p++) begin
      if (p == 0) begin
        wv = CFG_W'($urandom_range(65, 127));
        hv = CFG_W'(64);
      end else if (p == 6) begin
        wv = CFG_W'(3);
        hv = CFG_W'(3);
      end else if (p == 3) begin
        wv = CFG_W'($urandom_range(0, 2));
        hv = CFG_W'($urandom_range(3, 8));
      end else begin
        wv = CFG_W'($urandom_range(3, 16));
        hv = CFG_W'($urandom_range(3, 16));
      end
      quiet = 1'b0;
      write_reg(CFG_GRID_WIDTH, wv);
      write_reg(CFG_GRID_HEIGHT, hv);
      write_reg(CFG_BIRTH_MASK, pick_mask(BIRTH_MASK_RST));
      write_reg(CFG_SURVIVE_MASK, pick_mask(SURVIVE_MASK_RST));
      quiet = (p == 2) || (p == 5);
      w = used_dim(width_reg, MAX_WIDTH_DEF);
      h = used_dim(height_reg, MAX_HEIGHT_DEF);
      step_pct = (w * h > 1024) ? 4 : 20;
      for (int i = 0; i < 16; i++) begin
        // mid-phase rule change keeps the grid
        if (i == 8 && $urandom_range(0, 1)) write_reg(CFG_BIRTH_MASK, pick_mask(9'd72));
        it = random_beat(step_pct);
        send_beat(it, 1'b0, '0);
      end
    end

    // drain
    in_valid = 1'b0;
    quiet = 1'b0;
    while (want_q.size() != 0) @(negedge clk);
    repeat (20) @(posedge clk);
    if (err_cnt == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
hw/rtl/ttl_pkg.sv
hw/rtl/ttl_row_mem.sv
hw/rtl/ttl_cell_unit.sv
hw/rtl/ttl_seq.sv
hw/rtl/toroidal_life_like_automaton_top.sv
tb/tb_toroidal_life_like_automaton_top.sv
